// ===== sv/stk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package stk_pkg;

	localparam int DEFAULT_DEPTH = 64;

	localparam int VAL_W  = 32;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;
	localparam int POS_W  = 7;

	localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

	typedef logic signed [VAL_W-1:0] value_t;

endpackage

`default_nettype wire

// ===== sv/stk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module stk_ram import stk_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire value_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output value_t             rdata
);

	value_t mem [DEPTH];
	value_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/stack_with_value_search.sv =====
// push, no-op, full push, empty pop and empty search go from idle straight to the result state
// a pop off a non-empty stack goes through the pop state, which takes the top entry, then to result
// search stays in the search state until a match at position p from the top or p reaches the fill count
// the result state loads the output register once it is free; the next request is taken back in idle
// one request at a time; the search walks the entry memory one read per cycle
// reset clears the fill count and the output valid; the entry memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module stack_with_value_search import stk_pkg::*; #(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // value
	input  wire logic [1:0]  s_axis_tuser,  // req_type
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // data, position, zero pad
	output logic [2:0]       m_axis_tuser   // status, found
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_POP    = 2'd1;
	localparam logic [1:0] ST_SEARCH = 2'd2;
	localparam logic [1:0] ST_RESP   = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     pos_q;
	logic [AW-1:0]     scan_q;
	value_t            val_q;

	logic [STAT_W-1:0] res_status_q;
	value_t            res_data_q;
	logic              res_found_q;
	logic [POS_W-1:0]  res_pos_q;

	logic              m_valid_q;
	logic [STAT_W-1:0] m_status_q;
	value_t            m_data_q;
	logic              m_found_q;
	logic [POS_W-1:0]  m_pos_q;

	logic              accept;
	logic              full;
	logic              empty;
	logic              out_free;
	logic [CW-1:0]     fill_m1;
	logic [REQ_W-1:0]  req;
	value_t            in_value;

	logic              ram_we;
	logic [AW-1:0]     ram_raddr;
	value_t            ram_rdata;

	assign req      = s_axis_tuser;
	assign in_value = s_axis_tdata;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign fill_m1  = fill_q - CW'(1);
	assign out_free = !m_valid_q || m_axis_tready;

	assign ram_we    = accept && (req == REQ_PUSH) && !full;
	assign ram_raddr = (state_q == ST_SEARCH) ? scan_q : fill_m1[AW-1:0];

	stk_ram #(
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (in_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req)
							REQ_PUSH: begin
								state_q <= ST_RESP;
								if (!full) begin
									fill_q <= fill_q + CW'(1);
								end
							end
							REQ_POP: begin
								if (empty) begin
									state_q <= ST_RESP;
								end else begin
									state_q <= ST_POP;
									fill_q  <= fill_m1;
								end
							end
							REQ_SEARCH: begin
								state_q <= empty ? ST_RESP : ST_SEARCH;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_POP: begin
					state_q <= ST_RESP;
				end
				ST_SEARCH: begin
					if (ram_rdata == val_q || pos_q == fill_q) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_data_q   <= '0;
					res_found_q  <= 1'b0;
					res_pos_q    <= '0;
					val_q        <= in_value;
					pos_q        <= CW'(1);
					scan_q       <= AW'(fill_q - CW'(2));
					unique case (req)
						REQ_PUSH: begin
							res_status_q <= full ? STAT_FULL : STAT_OK;
						end
						REQ_POP: begin
							res_status_q <= empty ? STAT_EMPTY : STAT_OK;
						end
						REQ_SEARCH: begin
							res_status_q <= empty ? STAT_NOTFOUND : STAT_OK;
						end
						default: begin
							res_status_q <= STAT_OK;
						end
					endcase
				end
			end
			ST_POP: begin
				res_data_q <= ram_rdata;
			end
			ST_SEARCH: begin
				scan_q <= scan_q - AW'(1);
				pos_q  <= pos_q + CW'(1);
				if (ram_rdata == val_q) begin
					res_found_q <= 1'b1;
					res_pos_q   <= POS_W'(pos_q);
				end else if (pos_q == fill_q) begin
					res_status_q <= STAT_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			m_status_q <= res_status_q;
			m_data_q   <= res_data_q;
			m_found_q  <= res_found_q;
			m_pos_q    <= res_pos_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_pos_q, m_data_q};
	assign m_axis_tuser  = {m_found_q, m_status_q};

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count above depth");

	a_search_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEARCH) |-> (pos_q != '0 && pos_q <= fill_q))
		else $error("search position outside the stack");

	a_push_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req == REQ_PUSH && !full) |=> (fill_q == $past(fill_q) + CW'(1)))
		else $error("push did not advance fill count");

	a_pop_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req == REQ_POP && !empty)
			|=> (state_q == ST_POP && fill_q == $past(fill_q) - CW'(1)))
		else $error("pop did not retire top entry");

	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP && !out_free) |=> (state_q == ST_RESP))
		else $error("result dropped while output busy");

endmodule

`default_nettype wire

// ===== test/stack_with_value_search_test.sv =====
`timescale 1ns / 1ps

module stack_with_value_search_test;
	import stk_pkg::*;

	localparam int DEPTH = DEFAULT_DEPTH;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int ITEM_GOAL = 850;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PRESSURE_AT = 300;
	localparam int PRESSURE_LEN = 300;

	typedef struct {
		logic [STAT_W-1:0] status;
		value_t            data;
		logic              found;
		logic [POS_W-1:0]  position;
	} stack_result_t;

	typedef struct {
		logic [REQ_W-1:0] req;
		value_t           val;
		bit               typed;
		stack_result_t    want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	value_t        shadow_stack [DEPTH];
	int            shadow_fill = 0;
	stack_result_t results_due [$];
	stim_row_t     plan [$];
	int            items_sent = 0;
	int            beats_seen = 0;
	int            fail_count = 0;
	int            idle_pct = 0;
	int            stall_pct = 0;
	int            hold_left = 0;
	bit            pressure_done = 0;
	int            cycle_count = 0;

	stack_with_value_search #(.DEPTH(DEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic stack_result_t predict_stack(input logic [REQ_W-1:0] req,
			input value_t val);
		stack_result_t r;
		bit hit;
		r = '{STAT_OK, '0, 1'b0, '0};
		hit = 0;
		case (req)
			REQ_PUSH: begin
				if (shadow_fill >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					shadow_stack[shadow_fill] = val;
					shadow_fill++;
				end
			end
			REQ_POP: begin
				if (shadow_fill == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					shadow_fill--;
					r.data = shadow_stack[shadow_fill];
				end
			end
			REQ_SEARCH: begin
				for (int i = 1; i <= shadow_fill; i++) begin
					if (!hit && shadow_stack[shadow_fill - i] == val) begin
						hit = 1;
						r.found = 1'b1;
						r.position = i[POS_W-1:0];
					end
				end
				if (!hit)
					r.status = STAT_NOTFOUND;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic value_t pick_value();
		int roll;
		roll = $urandom_range(9);
		case (roll)
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3: return value_t'($urandom_range(4)) - 2;
			default: return value_t'($urandom);
		endcase
	endfunction

	function automatic value_t pick_search_value();
		if (shadow_fill > 0 && $urandom_range(9) < 6)
			return shadow_stack[$urandom_range(shadow_fill - 1)];
		return pick_value();
	endfunction

	task automatic add_row(input logic [REQ_W-1:0] req, input value_t val, input bit typed,
			input logic [STAT_W-1:0] st);
		stim_row_t row;
		row.req = req;
		row.val = val;
		row.typed = typed;
		row.want = '{st, '0, 1'b0, '0};
		plan.push_back(row);
	endtask

	task automatic pause_sender();
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = ($urandom_range(9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_request(input logic [REQ_W-1:0] req, input value_t val, input bit typed,
			input stack_result_t want);
		stack_result_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= val;
		do @(posedge clk); while (!s_axis_tready);
		predicted = predict_stack(req, val);
		results_due.push_back(typed ? want : predicted);
		items_sent++;
		pause_sender();
	endtask

	task automatic check_beat();
		stack_result_t want;
		beats_seen++;
		if (results_due.size() == 0) begin
			$error("unexpected result beat: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
			fail_count++;
		end else begin
			want = results_due.pop_front();
			if (m_axis_tuser[1:0] !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, m_axis_tuser[1:0]);
				fail_count++;
			end
			if (m_axis_tuser[2] !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, m_axis_tuser[2]);
				fail_count++;
			end
			if (m_axis_tdata[31:0] !== want.data) begin
				$error("data: expected %0d, got %0d", want.data, $signed(m_axis_tdata[31:0]));
				fail_count++;
			end
			if (m_axis_tdata[38:32] !== want.position) begin
				$error("position: expected %0d, got %0d", want.position, m_axis_tdata[38:32]);
				fail_count++;
			end
			if (m_axis_tdata[39] !== 1'b0) begin
				$error("pad: expected 0, got %0d", m_axis_tdata[39]);
				fail_count++;
			end
		end
	endtask

	// result side: random stalls, plus one long hold-off so the block backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_beat();
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (beats_seen >= PRESSURE_AT && !pressure_done) begin
				pressure_done = 1;
				hold_left = PRESSURE_LEN - 1;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(99) < stall_pct) begin
				hold_left = ($urandom_range(9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		stack_result_t none;
		logic [REQ_W-1:0] req;
		value_t val;
		int phase;
		int phase_len;
		int roll;
		bit first_phase;

		none = '{STAT_OK, '0, 1'b0, '0};
		first_phase = 1;

		add_row(REQ_POP,    32'sd0,          1, STAT_EMPTY);
		add_row(REQ_SEARCH, 32'sd0,          1, STAT_NOTFOUND);
		add_row(REQ_UNUSED, 32'sd0,          1, STAT_OK);
		add_row(REQ_PUSH,   32'sh7fffffff,   1, STAT_OK);
		add_row(REQ_PUSH,   32'sh80000000,   1, STAT_OK);
		add_row(REQ_PUSH,   32'sd0,          1, STAT_OK);
		add_row(REQ_PUSH,   -32'sd1,         1, STAT_OK);
		add_row(REQ_PUSH,   32'sd5,          1, STAT_OK);
		add_row(REQ_PUSH,   32'sd0,          0, STAT_OK);
		add_row(REQ_SEARCH, 32'sh7fffffff,   0, STAT_OK);
		add_row(REQ_SEARCH, 32'sd0,          0, STAT_OK);
		add_row(REQ_SEARCH, 32'sh80000000,   0, STAT_OK);
		add_row(REQ_SEARCH, 32'sh7ffffffe,   0, STAT_OK);
		add_row(REQ_SEARCH, 32'sh00000001,   0, STAT_OK);
		add_row(REQ_UNUSED, -32'sd1,         1, STAT_OK);
		add_row(REQ_POP,    32'sh12345678,   0, STAT_OK);
		add_row(REQ_POP,    32'sd0,          0, STAT_OK);
		add_row(REQ_POP,    32'sd0,          0, STAT_OK);
		add_row(REQ_SEARCH, -32'sd1,         0, STAT_OK);
		add_row(REQ_POP,    32'sd0,          0, STAT_OK);
		add_row(REQ_POP,    32'sd0,          0, STAT_OK);
		add_row(REQ_POP,    32'sd0,          0, STAT_OK);
		add_row(REQ_POP,    -32'sd1,         1, STAT_EMPTY);
		add_row(REQ_PUSH,   -32'sd1,         1, STAT_OK);
		add_row(REQ_SEARCH, -32'sd1,         0, STAT_OK);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 30;
		stall_pct = 30;
		foreach (plan[i])
			send_request(plan[i].req, plan[i].val, plan[i].typed, plan[i].want);

		while (items_sent < ITEM_GOAL) begin
			// fill, drain, mixed and noisy phases so both full and empty are reached
			phase = first_phase ? 0 : $urandom_range(3);
			phase_len = (phase < 2) ? $urandom_range(60, 120) : $urandom_range(20, 60);
			first_phase = 0;
			idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
			stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
			for (int n = 0; n < phase_len && items_sent < ITEM_GOAL; n++) begin
				roll = $urandom_range(99);
				case (phase)
					0: req = (roll < 80) ? REQ_PUSH : (roll < 95) ? REQ_SEARCH : REQ_POP;
					1: req = (roll < 75) ? REQ_POP : (roll < 95) ? REQ_SEARCH : REQ_PUSH;
					2: req = (roll < 40) ? REQ_PUSH : (roll < 75) ? REQ_POP : REQ_SEARCH;
					default: req = (roll < 10) ? REQ_UNUSED : (roll < 40) ? REQ_PUSH :
						(roll < 70) ? REQ_POP : REQ_SEARCH;
				endcase
				val = (req == REQ_SEARCH) ? pick_search_value() : pick_value();
				send_request(req, val, 0, none);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
